FILE: src/mmu_pkg.sv
// Shared types and constants of the matrix multiply unit.
package mmu_pkg;

	localparam int VAL_W  = 32;           // Q16.16 element width
	localparam int IDX_W  = 3;            // row and column field width
	localparam int DIM_W  = 4;            // size register width
	localparam int PROD_W = 2 * VAL_W;    // Q32.32 product
	localparam int ACC_W  = PROD_W + 4;   // room for eight products and rounding
	localparam int FULL_W = 2 * IDX_W + 1;
	localparam int REG_W  = 2;

	typedef enum logic [1:0] {
		MODE_WRITE_A = 2'd0,
		MODE_WRITE_B = 2'd1,
		MODE_START   = 2'd2
	} mode_t;

	typedef enum logic [REG_W-1:0] {
		REG_A_ROWS    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_B_COLS    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	// tag that travels with each operand pair into the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// finished dot product as seen by the sequencer
	typedef struct packed {
		logic                    done;
		logic                    sat;
		logic signed [VAL_W-1:0] value;
	} mac_res_t;

endpackage

FILE: src/mmu_channels.sv
// Handshake channels for element loads and result elements.
interface mmu_cmd_if;
	import mmu_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output mode, output row, output col, output value,
		input ready);
	modport sink (input valid, input mode, input row, input col, input value,
		output ready);
endinterface

interface mmu_res_if;
	import mmu_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [VAL_W-1:0] out_value;
	logic                    saturated;
	logic                    last;

	modport source (output valid, output out_row, output out_col, output out_value,
		output saturated, output last, input ready);
	modport sink (input valid, input out_row, input out_col, input out_value,
		input saturated, input last, output ready);
endinterface

FILE: src/matrix_multiply_unit.sv
// Top level: element stores, sequencer and result register of the matrix multiply unit.
//
//  channel  dir  payload                                      transfer
//  cmd      in   mode, row, col, value                        valid && ready
//  res      out  out_row, out_col, out_value, saturated, last valid && ready
//  cfg      in   cfg_index, cfg_data                          cfg_we
//
// A start runs every result element through the one multiply-accumulate unit, one
// product per cycle: each element passes through operand read, multiply and accumulate,
// and cmd is not ready while a start runs.
// A stalled res holds the sequencer before the next element is issued.
// Reset clears control and the size registers (8 each); stores hold garbage until written.
module matrix_multiply_unit #(
	parameter int MAX_DIM = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mmu_pkg::REG_W-1:0]    cfg_index,
	input  logic [mmu_pkg::DIM_W-1:0]    cfg_data,
	mmu_cmd_if.sink                      cmd,
	mmu_res_if.source                    res
);
	import mmu_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0] a_rows_q, inner_dim_q, b_cols_q;
	logic [DIM_W-1:0] nr, nk, nc;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [IDX_W-1:0] i_d, j_d, k_d;

	mac_ctl_t         ctl_s1, ctl_d;
	mac_res_t         mac_out;
	logic signed [VAL_W-1:0] a_rd, b_rd;

	logic             cmd_xfer;
	logic             we_a, we_b;
	logic [AW-1:0]    waddr, raddr_a, raddr_b;
	logic             k_end, j_end, i_end, load;

	logic                    res_valid_q;
	logic [IDX_W-1:0]        res_row_q, res_col_q;
	logic signed [VAL_W-1:0] res_value_q;
	logic                    res_sat_q, res_last_q;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		if (r == '0) begin
			return DIM_W'(1);
		end else if (r > DIM_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		logic [FULL_W-1:0] t;
		t = FULL_W'(r) * FULL_W'(MAX_DIM) + FULL_W'(c);
		return t[AW-1:0];
	endfunction

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_W'(8);
			inner_dim_q <= DIM_W'(8);
			b_cols_q    <= DIM_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_ROWS:    a_rows_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_B_COLS:    b_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr = eff_dim(a_rows_q);
	assign nk = eff_dim(inner_dim_q);
	assign nc = eff_dim(b_cols_q);

	// loads
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign we_a = cmd_xfer && (cmd.mode == MODE_WRITE_A) &&
		(DIM_W'(cmd.row) < nr) && (DIM_W'(cmd.col) < nk);
	assign we_b = cmd_xfer && (cmd.mode == MODE_WRITE_B) &&
		(DIM_W'(cmd.row) < nk) && (DIM_W'(cmd.col) < nc);
	assign waddr   = addr_of(cmd.row, cmd.col);
	assign raddr_a = addr_of(i_q, k_q);
	assign raddr_b = addr_of(k_q, j_q);

	mmu_mem #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (raddr_a),
		.rdata (a_rd)
	);

	mmu_mem #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (cmd.value),
		.raddr (raddr_b),
		.rdata (b_rd)
	);

	mmu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.a      (a_rd),
		.b      (b_rd),
		.clr    (load),
		.res    (mac_out)
	);

	// sequencer
	assign k_end = (DIM_W'(k_q) + DIM_W'(1)) == nk;
	assign j_end = (DIM_W'(j_q) + DIM_W'(1)) == nc;
	assign i_end = (DIM_W'(i_q) + DIM_W'(1)) == nr;
	assign load  = (state_q == ST_WAIT) && mac_out.done && (!res_valid_q || res.ready);

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		ctl_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_xfer && (cmd.mode == MODE_START)) begin
					state_d = ST_RUN;
					i_d     = '0;
					j_d     = '0;
					k_d     = '0;
				end
			end
			ST_RUN: begin
				ctl_d.valid = 1'b1;
				ctl_d.first = (k_q == '0);
				ctl_d.last  = k_end;
				if (k_end) begin
					k_d     = '0;
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + IDX_W'(1);
				end
			end
			ST_WAIT: begin
				if (load) begin
					if (i_end && j_end) begin
						state_d = ST_IDLE;
					end else if (j_end) begin
						j_d     = '0;
						i_d     = i_q + IDX_W'(1);
						state_d = ST_RUN;
					end else begin
						j_d     = j_q + IDX_W'(1);
						state_d = ST_RUN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ctl_s1  <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			ctl_s1  <= ctl_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_row_q   <= i_q;
			res_col_q   <= j_q;
			res_value_q <= mac_out.value;
			res_sat_q   <= mac_out.sat;
			res_last_q  <= i_end && j_end;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.out_row   = res_row_q;
	assign res.out_col   = res_col_q;
	assign res.out_value = res_value_q;
	assign res.saturated = res_sat_q;
	assign res.last      = res_last_q;

endmodule

FILE: src/mmu_mem.sv
// Element store: one write port, one registered read port.
module mmu_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic signed [mmu_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]                   raddr,
	output logic signed [mmu_pkg::VAL_W-1:0] rdata
);
	import mmu_pkg::*;

	logic signed [VAL_W-1:0] mem_q [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/mmu_mac.sv
// Shared multiply-accumulate unit with Q16.16 rounding and saturation.
module mmu_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mmu_pkg::mac_ctl_t               ctl,
	input  logic signed [mmu_pkg::VAL_W-1:0] a,
	input  logic signed [mmu_pkg::VAL_W-1:0] b,
	input  logic                            clr,
	output mmu_pkg::mac_res_t               res
);
	import mmu_pkg::*;

	mac_ctl_t                 ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  rnd;
	logic                     fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	// hold done until the sequencer moves the result out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (clr) begin
			done_q <= 1'b0;
		end else if (ctl_s2.valid && ctl_s2.last) begin
			done_q <= 1'b1;
		end
	end

	// round half up, then the value fits when bits 47 and above agree
	assign rnd  = acc_q + ACC_W'(32768);
	assign fits = (&rnd[ACC_W-1:47]) || !(|rnd[ACC_W-1:47]);

	always_comb begin
		res.done = done_q;
		res.sat  = !fits;
		if (fits) begin
			res.value = rnd[47:16];
		end else if (rnd[ACC_W-1]) begin
			res.value = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			res.value = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

endmodule
